FILE: rtl/core/ifrc_pkg.sv
// Shared types and constants for the image flip, rotate and crop engine.
`timescale 1ns / 1ps

package ifrc_pkg;

    // Transform modes; the two codes above extract pass the frame through.
    typedef enum logic [2:0] {
        MODE_FLIP_H  = 3'd0,
        MODE_FLIP_V  = 3'd1,
        MODE_ROT_R   = 3'd2,
        MODE_ROT_L   = 3'd3,
        MODE_CROP    = 3'd4,
        MODE_EXTRACT = 3'd5
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_MODE         = 3'd0,
        CFG_FRAME_WIDTH  = 3'd1,
        CFG_FRAME_HEIGHT = 3'd2,
        CFG_CROP_LEFT    = 3'd3,
        CFG_CROP_TOP     = 3'd4,
        CFG_CROP_WIDTH   = 3'd5,
        CFG_CROP_HEIGHT  = 3'd6,
        CFG_CHANNEL_MASK = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        KIND_STORE   = 1'b0,
        KIND_REQUEST = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CALC,
        ST_ADDR,
        ST_READ,
        ST_LOAD
    } t_state;

    localparam int CFG_DATA_W = 9;
    localparam int PIXEL_W    = 24;

    localparam int KEEP_BLUE_BIT  = 0;
    localparam int KEEP_GREEN_BIT = 1;
    localparam int KEEP_RED_BIT   = 2;

    typedef struct packed {
        logic [2:0] mode;
        logic [8:0] frame_width;
        logic [8:0] frame_height;
        logic [7:0] crop_left;
        logic [7:0] crop_top;
        logic [8:0] crop_width;
        logic [8:0] crop_height;
        logic [2:0] channel_mask;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        mode:         3'd0,
        frame_width:  9'd256,
        frame_height: 9'd256,
        crop_left:    8'd0,
        crop_top:     8'd0,
        crop_width:   9'd1,
        crop_height:  9'd1,
        channel_mask: 3'd7
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic store;
        logic calc;
        logic addr;
        logic read;
        logic load;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_ctrl_sts;

endpackage

FILE: rtl/core/ifrc_ctrl.sv
// Controller state machine that sequences store and request transactions.
`timescale 1ns / 1ps

module ifrc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_kind,
    output logic                  o_s_tready,
    input  ifrc_pkg::t_ctrl_sts   i_sts,
    output ifrc_pkg::t_ctrl_cmd   o_cmd
);
    import ifrc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_kind == KIND_REQUEST) ? ST_CALC : ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_cmd.store = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = ST_ADDR;
            end
            ST_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = ST_READ;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_LOAD;
            end
            ST_LOAD: begin
                // Wait until the output register can take the result.
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/ifrc_datapath.sv
// Datapath: frame store, write position, output counters, address unit and output register.
`timescale 1ns / 1ps

module ifrc_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ifrc_pkg::t_ctrl_cmd       i_cmd,
    output ifrc_pkg::t_ctrl_sts       o_sts,
    input  ifrc_pkg::t_cfg            i_cfg,
    input  logic [ifrc_pkg::PIXEL_W-1:0] i_pixel,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [ifrc_pkg::PIXEL_W-1:0] o_m_tdata,
    output logic                      o_m_tlast,
    output logic                      o_m_tuser
);
    import ifrc_pkg::*;

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DW      = $clog2(MAX_DIM + 1);
    localparam int CW      = $clog2(MAX_DIM);
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = $clog2(DEPTH);
    localparam int TW      = $clog2(DEPTH + 1);
    localparam int EW      = ((DW > 9) ? DW : 9) + 1;
    localparam int PW      = CW + DW;

    logic [PIXEL_W-1:0] mem [DEPTH];

    logic [DW-1:0]      w, h, ow, oh;
    logic [2*DW-1:0]    total_prod;
    logic [TW-1:0]      r_total;
    logic [AW-1:0]      r_wpos, wpos_eff, n_wpos;
    logic [TW-1:0]      wpos_inc;
    logic [PIXEL_W-1:0] r_pix;

    logic [9:0]         crop_right, crop_bottom;
    logic               err;
    logic [CW-1:0]      r_row, r_col, rr, cc;
    logic [EW-1:0]      sr_e, sc_e;
    logic [CW-1:0]      r_sr, r_sc, r_crow, r_ccol;
    logic               r_err;
    logic [2:0]         r_keep;
    logic [PW-1:0]      addr_prod;
    logic [AW-1:0]      r_addr;
    logic [PIXEL_W-1:0] r_rd;

    logic               frame_end;
    logic [CW:0]        col_inc;
    logic [PIXEL_W-1:0] masked_pix;

    logic               r_out_valid;
    logic [PIXEL_W-1:0] r_out_pix;
    logic               r_out_last;
    logic               r_out_bad;

    // Saturate the source size to the store limits.
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            w = DW'(1);
        end else if (int'(i_cfg.frame_width) > MAX_WIDTH) begin
            w = DW'(MAX_WIDTH);
        end else begin
            w = DW'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == '0) begin
            h = DW'(1);
        end else if (int'(i_cfg.frame_height) > MAX_HEIGHT) begin
            h = DW'(MAX_HEIGHT);
        end else begin
            h = DW'(i_cfg.frame_height);
        end
    end

    // Output frame size.
    always_comb begin
        case (i_cfg.mode)
            MODE_ROT_R, MODE_ROT_L: begin
                ow = h;
                oh = w;
            end
            MODE_CROP: begin
                ow = DW'(i_cfg.crop_width);
                oh = DW'(i_cfg.crop_height);
            end
            default: begin
                ow = w;
                oh = h;
            end
        endcase
    end

    assign crop_right  = {2'b00, i_cfg.crop_left} + {1'b0, i_cfg.crop_width};
    assign crop_bottom = {2'b00, i_cfg.crop_top} + {1'b0, i_cfg.crop_height};

    always_comb begin
        err = 1'b0;
        if (i_cfg.mode == MODE_CROP) begin
            err = (i_cfg.crop_width == '0) || (i_cfg.crop_height == '0)
               || (int'(i_cfg.crop_left) >= int'(w)) || (int'(i_cfg.crop_top) >= int'(h))
               || (int'(crop_right) > int'(w)) || (int'(crop_bottom) > int'(h));
        end else if (i_cfg.mode == MODE_EXTRACT) begin
            err = (i_cfg.channel_mask == '0);
        end
    end

    // Counters left outside the output size by a configuration change restart at zero.
    assign rr = (int'(r_row) >= int'(oh)) ? '0 : r_row;
    assign cc = (int'(r_col) >= int'(ow)) ? '0 : r_col;

    // Source coordinates of the current output pixel.
    always_comb begin
        case (i_cfg.mode)
            MODE_FLIP_H: begin
                sr_e = EW'(rr);
                sc_e = EW'(w) - EW'(1) - EW'(cc);
            end
            MODE_FLIP_V: begin
                sr_e = EW'(h) - EW'(1) - EW'(rr);
                sc_e = EW'(cc);
            end
            MODE_ROT_R: begin
                sr_e = EW'(h) - EW'(1) - EW'(cc);
                sc_e = EW'(rr);
            end
            MODE_ROT_L: begin
                sr_e = EW'(cc);
                sc_e = EW'(w) - EW'(1) - EW'(rr);
            end
            MODE_CROP: begin
                sr_e = EW'(i_cfg.crop_top) + EW'(rr);
                sc_e = EW'(i_cfg.crop_left) + EW'(cc);
            end
            default: begin
                sr_e = EW'(rr);
                sc_e = EW'(cc);
            end
        endcase
    end

    assign total_prod = w * h;
    assign addr_prod  = r_sr * w;

    // The write position restarts when it reaches the end of the frame.
    assign wpos_eff = (TW'(r_wpos) >= r_total) ? '0 : r_wpos;
    assign wpos_inc = TW'(wpos_eff) + TW'(1);
    assign n_wpos   = (wpos_inc >= r_total) ? '0 : AW'(wpos_inc);

    assign frame_end = (int'(r_crow) == int'(oh) - 1) && (int'(r_ccol) == int'(ow) - 1);
    assign col_inc   = (CW + 1)'(r_ccol) + (CW + 1)'(1);

    assign masked_pix = {
        r_keep[KEEP_RED_BIT]   ? r_rd[23:16] : 8'd0,
        r_keep[KEEP_GREEN_BIT] ? r_rd[15:8]  : 8'd0,
        r_keep[KEEP_BLUE_BIT]  ? r_rd[7:0]   : 8'd0
    };

    assign o_sts.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[wpos_eff] <= r_pix;
        end
        if (i_cmd.read) begin
            r_rd <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= TW'(total_prod);
        if (i_cmd.capture) begin
            r_pix <= i_pixel;
        end
        if (i_cmd.calc) begin
            r_sr   <= CW'(sr_e);
            r_sc   <= CW'(sc_e);
            r_crow <= rr;
            r_ccol <= cc;
            r_err  <= err;
            r_keep <= (i_cfg.mode == MODE_EXTRACT) ? i_cfg.channel_mask : 3'b111;
        end
        if (i_cmd.addr) begin
            r_addr <= AW'(addr_prod + PW'(r_sc));
        end
        if (i_cmd.load) begin
            if (r_err) begin
                r_out_pix  <= '0;
                r_out_last <= 1'b0;
                r_out_bad  <= 1'b1;
            end else begin
                r_out_pix  <= masked_pix;
                r_out_last <= frame_end;
                r_out_bad  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_wpos <= n_wpos;
            end
            if (i_cmd.load && !r_err) begin
                if (frame_end) begin
                    r_row <= '0;
                    r_col <= '0;
                end else if (int'(col_inc) >= int'(ow)) begin
                    r_col <= '0;
                    r_row <= r_crow + CW'(1);
                end else begin
                    r_col <= CW'(col_inc);
                    r_row <= r_crow;
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pix;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_bad;

endmodule

FILE: rtl/core/image_flip_rotate_crop_engine.sv
// Top level of the image flip, rotate and crop engine with its configuration registers.
`timescale 1ns / 1ps

// A store transaction (tuser 0) writes one BGR pixel into the frame store in source
// raster order; it gives no result. A request transaction (tuser 1) returns the next
// pixel of the transformed frame in output raster order; it holds the engine through
// its steps: bring the output coordinates into range and map them, form the address
// with one multiply-add, read the single-port frame store of MAX_WIDTH * MAX_HEIGHT
// entries, and load the output register. One transaction is in work at a time; a
// finished result sits in the output register while the next transaction is
// accepted, and a following request waits only if that result has not yet been
// taken. tlast marks the last pixel of the output frame, and tuser on the result
// flags an invalid crop window or an empty channel mask, in which case the pixel is
// zero and the output position does not move. The user must write configuration
// only while no transaction is in work; the block itself does not enforce it.
module image_flip_rotate_crop_engine #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_idx,
    input  logic [ifrc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ifrc_pkg::PIXEL_W-1:0]        s_axis_tdata,  // in_blue, in_green, in_red
    input  logic                                s_axis_tuser,  // kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ifrc_pkg::PIXEL_W-1:0]        m_axis_tdata,  // out_blue, out_green, out_red
    output logic                                m_axis_tlast,  // frame_end
    output logic                                m_axis_tuser   // bad_setup
);
    import ifrc_pkg::*;

    t_cfg      r_cfg;
    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:         r_cfg.mode         <= i_cfg_data[2:0];
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[8:0];
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[8:0];
                CFG_CROP_LEFT:    r_cfg.crop_left    <= i_cfg_data[7:0];
                CFG_CROP_TOP:     r_cfg.crop_top     <= i_cfg_data[7:0];
                CFG_CROP_WIDTH:   r_cfg.crop_width   <= i_cfg_data[8:0];
                CFG_CROP_HEIGHT:  r_cfg.crop_height  <= i_cfg_data[8:0];
                CFG_CHANNEL_MASK: r_cfg.channel_mask <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    ifrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_kind     (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ifrc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg      (r_cfg),
        .i_pixel    (s_axis_tdata),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser)
    );

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a pending result");

    // An error result carries a zero pixel and no frame end.
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0 && !m_axis_tlast))
        else $error("error result with nonzero payload");

    // A store transaction is followed by a frame store write and never by a result load.
    a_store_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_STORE)
            |=> (w_cmd.store && !w_cmd.load))
        else $error("store transaction did not write the frame store");

    // The input side stays closed while a transaction writes, maps, addresses or reads.
    a_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.calc || w_cmd.addr || w_cmd.read || w_cmd.store) |-> !s_axis_tready)
        else $error("input accepted while busy");

endmodule

FILE: tb/sv/image_flip_rotate_crop_engine_tb.sv
// Self-checking testbench for the image flip, rotate, crop and extract engine.
`timescale 1ns / 1ps

module image_flip_rotate_crop_engine_tb;

    import ifrc_pkg::*;

    localparam int         FRAME_DIM_MAX  = 256;
    localparam int         RANDOM_ITEMS   = 1000;
    localparam int         SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_end;
        logic       bad_setup;
    } t_out_pixel;

    class pixel_scoreboard;
        logic [PIXEL_W-1:0] frame_mem [FRAME_DIM_MAX * FRAME_DIM_MAX];
        int unsigned        wr_pos;
        int unsigned        row;
        int unsigned        col;
        t_cfg               regs = CFG_RESET;
        t_out_pixel         expected_pixels [$];
        int                 errors;

        function int unsigned clamp_dim(logic [8:0] v);
            if (v == 0) return 1;
            if (v > FRAME_DIM_MAX) return FRAME_DIM_MAX;
            return v;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [8:0] val);
            case (idx)
                CFG_MODE:         regs.mode = val[2:0];
                CFG_FRAME_WIDTH:  regs.frame_width = val;
                CFG_FRAME_HEIGHT: regs.frame_height = val;
                CFG_CROP_LEFT:    regs.crop_left = val[7:0];
                CFG_CROP_TOP:     regs.crop_top = val[7:0];
                CFG_CROP_WIDTH:   regs.crop_width = val;
                CFG_CROP_HEIGHT:  regs.crop_height = val;
                CFG_CHANNEL_MASK: regs.channel_mask = val[2:0];
                default: begin
                end
            endcase
        endfunction

        // Stores a pixel, or works out the next output pixel of the transformed frame.
        function void accept_item(t_kind kind, logic [PIXEL_W-1:0] pix);
            int unsigned        w;
            int unsigned        h;
            int unsigned        ow;
            int unsigned        oh;
            int unsigned        sr;
            int unsigned        sc;
            logic [2:0]         keep;
            logic [PIXEL_W-1:0] word;
            t_out_pixel         res;
            w = clamp_dim(regs.frame_width);
            h = clamp_dim(regs.frame_height);
            if (kind == KIND_STORE) begin
                if (wr_pos >= w * h) wr_pos = 0;
                frame_mem[wr_pos] = pix;
                wr_pos++;
                if (wr_pos >= w * h) wr_pos = 0;
                return;
            end
            res = '0;
            if ((regs.mode == MODE_CROP && (regs.crop_width == 0 || regs.crop_height == 0
                    || regs.crop_left >= w || regs.crop_top >= h
                    || regs.crop_left + regs.crop_width > w
                    || regs.crop_top + regs.crop_height > h))
                    || (regs.mode == MODE_EXTRACT && regs.channel_mask == 0)) begin
                res.bad_setup = 1'b1;
                expected_pixels.push_back(res);
                return;
            end
            case (regs.mode)
                MODE_ROT_R, MODE_ROT_L: begin
                    ow = h;
                    oh = w;
                end
                MODE_CROP: begin
                    ow = regs.crop_width;
                    oh = regs.crop_height;
                end
                default: begin
                    ow = w;
                    oh = h;
                end
            endcase
            // A size change between frames can leave the position outside the new frame.
            if (row >= oh) row = 0;
            if (col >= ow) col = 0;
            case (regs.mode)
                MODE_FLIP_H: begin
                    sr = row;
                    sc = w - 1 - col;
                end
                MODE_FLIP_V: begin
                    sr = h - 1 - row;
                    sc = col;
                end
                MODE_ROT_R: begin
                    sr = h - 1 - col;
                    sc = row;
                end
                MODE_ROT_L: begin
                    sr = col;
                    sc = w - 1 - row;
                end
                MODE_CROP: begin
                    sr = regs.crop_top + row;
                    sc = regs.crop_left + col;
                end
                default: begin
                    sr = row;
                    sc = col;
                end
            endcase
            word = frame_mem[sr * w + sc];
            keep = (regs.mode == MODE_EXTRACT) ? regs.channel_mask : 3'b111;
            res.blue  = keep[KEEP_BLUE_BIT]  ? word[7:0]   : 8'd0;
            res.green = keep[KEEP_GREEN_BIT] ? word[15:8]  : 8'd0;
            res.red   = keep[KEEP_RED_BIT]   ? word[23:16] : 8'd0;
            if (row == oh - 1 && col == ow - 1) begin
                res.frame_end = 1'b1;
                row = 0;
                col = 0;
            end else begin
                col++;
                if (col >= ow) begin
                    col = 0;
                    row++;
                end
            end
            expected_pixels.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(logic [PIXEL_W-1:0] data, logic last, logic user);
            t_out_pixel want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result transaction: tdata %h tlast %b tuser %b",
                       data, last, user);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("out_blue", want.blue, data[7:0]);
            compare_field("out_green", want.green, data[15:8]);
            compare_field("out_red", want.red, data[23:16]);
            compare_field("frame_end", want.frame_end, last);
            compare_field("bad_setup", want.bad_setup, user);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [2:0]            i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIXEL_W-1:0]    s_axis_tdata = '0;  // in_blue, in_green, in_red
    logic                  s_axis_tuser = 1'b0;  // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIXEL_W-1:0]    m_axis_tdata;  // out_blue, out_green, out_red
    logic                  m_axis_tlast;  // frame_end
    logic                  m_axis_tuser;  // bad_setup

    pixel_scoreboard board = new();
    int              burst_left = 0;
    int              rx_cycle = 0;
    int              rx_style = 0;
    int              rx_hold = 0;

    image_flip_rotate_crop_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("image_flip_rotate_crop_engine verification failed");
        $finish;
    end

    // The result side is checked before the input side so that a result never
    // meets the expectation of the transaction accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_pixel(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                board.accept_item(t_kind'(s_axis_tuser), s_axis_tdata);
        end
    end

    // Receiver backpressure switches between free flow, a fixed duty cycle,
    // sparse random readiness and long stalls.
    always @(posedge i_clk) begin
        if (rx_cycle % 97 == 0) rx_style = $urandom_range(0, 3);
        case (rx_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= (rx_cycle % 4) != 3;
            2: m_axis_tready <= $urandom_range(0, 9) < 3;
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_axis_tready <= 1'b0;
                end else begin
                    if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(5, 20);
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
        rx_cycle++;
    end

    task automatic write_cfg(t_cfg_idx idx, logic [8:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        board.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_item(t_kind kind, logic [PIXEL_W-1:0] pix);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tuser <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    // Waits until every expected pixel has come out and the engine has gone quiet.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [PIXEL_W-1:0] extreme_pix [6];
        int unsigned        fw;
        int unsigned        fh;
        int unsigned        ew;
        int unsigned        eh;
        int unsigned        cl;
        int unsigned        ct;
        int unsigned        n;
        int unsigned        items;
        int                 sel;
        extreme_pix = '{24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555, 24'h0000FF, 24'hFF0000};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A 2 x 3 frame of extreme pixels, then one request in every mode.
        write_cfg(CFG_FRAME_WIDTH, 9'd2);
        write_cfg(CFG_FRAME_HEIGHT, 9'd3);
        for (int i = 0; i < 6; i++) push_item(KIND_STORE, extreme_pix[i]);
        for (int m = 0; m < 8; m++) begin
            drain();
            if (m == MODE_CROP) begin
                write_cfg(CFG_CROP_LEFT, 9'd1);
                write_cfg(CFG_CROP_TOP, 9'd1);
                write_cfg(CFG_CROP_HEIGHT, 9'd2);
            end
            if (m == MODE_EXTRACT) write_cfg(CFG_CHANNEL_MASK, 9'b101);
            write_cfg(CFG_MODE, 9'(m));
            push_item(KIND_REQUEST, 24'($urandom));
        end

        // Bad crop windows: zero width, overrun on the right, start past the frame; then an empty mask.
        drain();
        write_cfg(CFG_MODE, MODE_CROP);
        write_cfg(CFG_CROP_WIDTH, 9'd0);
        push_item(KIND_REQUEST, 24'($urandom));
        drain();
        write_cfg(CFG_CROP_WIDTH, 9'd2);
        push_item(KIND_REQUEST, 24'($urandom));
        drain();
        write_cfg(CFG_CROP_LEFT, 9'd2);
        write_cfg(CFG_CROP_WIDTH, 9'd1);
        push_item(KIND_REQUEST, 24'($urandom));
        drain();
        write_cfg(CFG_MODE, MODE_EXTRACT);
        write_cfg(CFG_CHANNEL_MASK, 9'd0);
        push_item(KIND_REQUEST, 24'($urandom));

        // Random setups: each fills a whole frame so no unwritten entry is read,
        // then mixes requests with further stores.
        items = 0;
        while (items < RANDOM_ITEMS) begin
            drain();
            sel = $urandom_range(0, 29);
            case (sel)
                0: begin
                    fw = $urandom_range(0, 1) ? FRAME_DIM_MAX : $urandom_range(257, 511);
                    fh = 1;
                end
                1: begin
                    fw = 1;
                    fh = $urandom_range(0, 1) ? FRAME_DIM_MAX : $urandom_range(257, 511);
                end
                2: begin
                    fw = 0;
                    fh = $urandom_range(1, 8);
                end
                3: begin
                    fw = $urandom_range(1, 8);
                    fh = 0;
                end
                default: begin
                    fw = $urandom_range(1, 12);
                    fh = $urandom_range(1, 12);
                end
            endcase
            ew = board.clamp_dim(9'(fw));
            eh = board.clamp_dim(9'(fh));
            write_cfg(CFG_FRAME_WIDTH, 9'(fw));
            write_cfg(CFG_FRAME_HEIGHT, 9'(fh));
            if ($urandom_range(0, 3) == 0) begin
                // Windows drawn without regard to the frame are mostly invalid.
                write_cfg(CFG_CROP_LEFT, 9'($urandom_range(0, 255)));
                write_cfg(CFG_CROP_TOP, 9'($urandom_range(0, 255)));
                write_cfg(CFG_CROP_WIDTH, 9'($urandom_range(0, 256)));
                write_cfg(CFG_CROP_HEIGHT, 9'($urandom_range(0, 256)));
            end else begin
                cl = $urandom_range(0, ew - 1);
                ct = $urandom_range(0, eh - 1);
                write_cfg(CFG_CROP_LEFT, 9'(cl));
                write_cfg(CFG_CROP_TOP, 9'(ct));
                write_cfg(CFG_CROP_WIDTH, 9'($urandom_range(1, ew - cl)));
                write_cfg(CFG_CROP_HEIGHT, 9'($urandom_range(1, eh - ct)));
            end
            write_cfg(CFG_CHANNEL_MASK, 9'($urandom_range(0, 7)));
            write_cfg(CFG_MODE, 9'($urandom_range(0, 7)));
            repeat (ew * eh) push_item(KIND_STORE, 24'($urandom));
            n = $urandom_range(8, 60);
            repeat (n) begin
                push_item(($urandom_range(0, 3) == 0) ? KIND_STORE : KIND_REQUEST,
                          24'($urandom));
            end
            items += ew * eh + n;
        end
        drain();

        if (board.errors == 0 && board.expected_pixels.size() == 0)
            $display("image_flip_rotate_crop_engine verification clean");
        else
            $display("image_flip_rotate_crop_engine verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ifrc_pkg.sv
rtl/core/ifrc_ctrl.sv
rtl/core/ifrc_datapath.sv
rtl/core/image_flip_rotate_crop_engine.sv
tb/sv/image_flip_rotate_crop_engine_tb.sv
